// ===== hw/rtl/hpd_pkg.sv =====
// ----------------------------------------------------------------------------
// hpd_pkg
// Shared widths, register indexes and types of the H-bridge PWM drive.
// ----------------------------------------------------------------------------
package hpd_pkg;

    localparam int POWER_W    = 9;
    localparam int CMD_W      = 10;
    localparam int LEG_W      = 8;
    localparam int PERIOD_W   = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;

    localparam logic [LEG_W-1:0]    DUTY_MAX     = 8'd255;
    localparam logic [LEG_W-1:0]    LEVEL_ON     = 8'd1;
    localparam logic [PERIOD_W-1:0] PERIOD_RESET = 8'd20;

    localparam logic [CFG_IDX_W-1:0] CFG_INVERSE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HW_PWM  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PERIOD  = 2'd2;

    typedef struct packed {
        logic                inverse;
        logic                hw_pwm;
        logic [PERIOD_W-1:0] period;
    } t_cfg;

    typedef struct packed {
        logic                changed;
        logic [CMD_W-1:0]    cmd;
        logic                brake;
        logic [LEG_W-1:0]    leg_a;
        logic [LEG_W-1:0]    leg_b;
        logic [PERIOD_W-1:0] phase;
    } t_calc;

endpackage

// ===== hw/rtl/hpd_ifs.sv =====
// ----------------------------------------------------------------------------
// hpd_ifs
// Command, result and register write channels of the H-bridge PWM drive.
// ----------------------------------------------------------------------------
interface hpd_in_if;
    import hpd_pkg::*;
    logic                      valid;
    logic                      ready;
    logic signed [POWER_W-1:0] power;
    logic                      brake_write;
    logic                      brake_value;

    modport source (output valid, output power, output brake_write,
                    output brake_value, input ready);
    modport sink   (input valid, input power, input brake_write,
                    input brake_value, output ready);
endinterface

interface hpd_out_if;
    import hpd_pkg::*;
    logic             valid;
    logic             ready;
    logic             blanking;
    logic [LEG_W-1:0] leg_a;
    logic [LEG_W-1:0] leg_b;
    logic             last;

    modport source (output valid, output blanking, output leg_a, output leg_b,
                    output last, input ready);
    modport sink   (input valid, input blanking, input leg_a, input leg_b,
                    input last, output ready);
endinterface

interface hpd_cfg_if;
    import hpd_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== hw/rtl/hpd_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// hpd_cfg_regs
// Register file: direction inversion, PWM mode and software PWM period.
// ----------------------------------------------------------------------------
module hpd_cfg_regs (
    input  logic          i_clk,
    input  logic          i_rst_n,
    hpd_cfg_if.sink       i_cfg,
    output hpd_pkg::t_cfg o_cfg
);
    import hpd_pkg::*;

    t_cfg r_cfg;
    t_cfg n_cfg;

    assign i_cfg.ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg.valid) begin
            unique case (i_cfg.index)
                CFG_INVERSE: n_cfg.inverse = i_cfg.data[0];
                CFG_HW_PWM:  n_cfg.hw_pwm  = i_cfg.data[0];
                CFG_PERIOD:  n_cfg.period  = i_cfg.data[PERIOD_W-1:0];
                default:     n_cfg         = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.inverse <= 1'b0;
            r_cfg.hw_pwm  <= 1'b1;
            r_cfg.period  <= PERIOD_RESET;
        end else begin
            r_cfg <= n_cfg;
        end
    end

endmodule

// ===== hw/rtl/hpd_calc.sv =====
// ----------------------------------------------------------------------------
// hpd_calc
// Leg drive for one command word: inversion, change detect, clamp, duty or
// software PWM compare, brake, and the next phase.
// ----------------------------------------------------------------------------
module hpd_calc (
    input  hpd_pkg::t_cfg                      i_cfg,
    input  logic signed [hpd_pkg::POWER_W-1:0] i_power,
    input  logic                               i_brake_write,
    input  logic                               i_brake_value,
    input  logic [hpd_pkg::CMD_W-1:0]          i_prev,
    input  logic [hpd_pkg::PERIOD_W-1:0]       i_phase,
    input  logic                               i_brake,
    output hpd_pkg::t_calc                     o_calc
);
    import hpd_pkg::*;

    logic signed [CMD_W-1:0]    w_raw;
    logic signed [CMD_W-1:0]    w_cmd;
    logic signed [CMD_W-1:0]    w_clamp;
    logic signed [CMD_W-1:0]    w_abs;
    logic [LEG_W-1:0]           w_mag;
    logic [2*LEG_W-1:0]         w_phase_prod;
    logic [2*LEG_W-1:0]         w_period_prod;
    logic [LEG_W-1:0]           w_drive;
    logic [LEG_W-1:0]           w_full;
    logic [PERIOD_W:0]          w_phase_inc;

    assign w_raw = CMD_W'(i_power);
    assign w_cmd = i_cfg.inverse ? -w_raw : w_raw;

    always_comb begin
        if (w_cmd > $signed({2'b00, DUTY_MAX})) begin
            w_clamp = $signed({2'b00, DUTY_MAX});
        end else if (w_cmd < -$signed({2'b00, DUTY_MAX})) begin
            w_clamp = -$signed({2'b00, DUTY_MAX});
        end else begin
            w_clamp = w_cmd;
        end
    end

    assign w_abs = w_clamp[CMD_W-1] ? -w_clamp : w_clamp;
    assign w_mag = w_abs[LEG_W-1:0];

    // phase * 255 as phase * 256 - phase
    assign w_phase_prod  = {i_phase, 8'd0} - {8'd0, i_phase};
    assign w_period_prod = (2*LEG_W)'(i_cfg.period) * (2*LEG_W)'(w_mag);

    assign w_drive = i_cfg.hw_pwm ? w_mag
                                  : {{(LEG_W-1){1'b0}}, (w_phase_prod < w_period_prod)};
    assign w_full  = i_cfg.hw_pwm ? DUTY_MAX : LEVEL_ON;

    assign w_phase_inc = {1'b0, i_phase} + (PERIOD_W+1)'(1);

    always_comb begin
        o_calc.changed = (w_cmd != $signed(i_prev));
        o_calc.cmd     = w_cmd;
        o_calc.brake   = i_brake_write ? i_brake_value : i_brake;
        o_calc.leg_a   = '0;
        o_calc.leg_b   = '0;
        if (w_clamp != '0) begin
            if (!w_clamp[CMD_W-1]) begin
                o_calc.leg_a = w_drive;
            end else begin
                o_calc.leg_b = w_drive;
            end
        end else if (o_calc.brake) begin
            o_calc.leg_a = w_full;
            o_calc.leg_b = w_full;
        end
        o_calc.phase = (w_phase_inc > {1'b0, i_cfg.period}) ? '0
                                                          : w_phase_inc[PERIOD_W-1:0];
    end

endmodule

// ===== hw/rtl/hbridge_pwm_drive.sv =====
// ----------------------------------------------------------------------------
// hbridge_pwm_drive
// Two-leg H-bridge drive from a signed power command per PWM tick.
// ----------------------------------------------------------------------------
// Each command word yields one result word, or two when the command differs
// from the previous one: a blanking word with both legs off, then the drive
// word marked last. A repeated command yields only the drive word, so a new
// word can be taken every cycle while the output is not stalled; a changed
// command sends both words in turn through the single result register. The
// input register takes the next command while a result waits downstream if it
// is empty. Leg values are duty 0..255 in hardware PWM mode and levels 0/1 in
// software PWM mode, where an internal phase counter advances once per command.
module hbridge_pwm_drive (
    input  logic      i_clk,
    input  logic      i_rst_n,
    hpd_in_if.sink    i_in,
    hpd_out_if.source o_out,
    hpd_cfg_if.sink   i_cfg
);
    import hpd_pkg::*;

    t_cfg  w_cfg;
    t_calc w_calc;

    logic                      r_in_valid;
    logic signed [POWER_W-1:0] r_power;
    logic                      r_brake_write;
    logic                      r_brake_value;
    logic                      r_blank_done;

    logic [CMD_W-1:0]          r_prev;
    logic [PERIOD_W-1:0]       r_phase;
    logic                      r_brake;

    logic                      r_out_valid;
    logic                      r_out_blanking;
    logic [LEG_W-1:0]          r_out_leg_a;
    logic [LEG_W-1:0]          r_out_leg_b;
    logic                      r_out_last;

    logic                      w_load_ok;
    logic                      w_need_blank;
    logic                      w_emit;
    logic                      w_retire;
    logic                      w_take;

    hpd_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (w_cfg)
    );

    hpd_calc u_calc (
        .i_cfg         (w_cfg),
        .i_power       (r_power),
        .i_brake_write (r_brake_write),
        .i_brake_value (r_brake_value),
        .i_prev        (r_prev),
        .i_phase       (r_phase),
        .i_brake       (r_brake),
        .o_calc        (w_calc)
    );

    assign w_load_ok    = !r_out_valid || o_out.ready;
    assign w_need_blank = w_calc.changed && !r_blank_done;
    assign w_emit       = r_in_valid && w_load_ok;
    assign w_retire     = w_emit && !w_need_blank;
    assign i_in.ready   = !r_in_valid || w_retire;
    assign w_take       = i_in.valid && i_in.ready;

    assign o_out.valid    = r_out_valid;
    assign o_out.blanking = r_out_blanking;
    assign o_out.leg_a    = r_out_leg_a;
    assign o_out.leg_b    = r_out_leg_b;
    assign o_out.last     = r_out_last;

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid   <= 1'b0;
            r_blank_done <= 1'b0;
            r_out_valid  <= 1'b0;
            r_prev       <= '0;
            r_phase      <= '0;
            r_brake      <= 1'b0;
        end else begin
            if (w_take) begin
                r_in_valid <= 1'b1;
            end else if (w_retire) begin
                r_in_valid <= 1'b0;
            end

            if (w_retire) begin
                r_blank_done <= 1'b0;
            end else if (w_emit) begin
                r_blank_done <= 1'b1;
            end

            if (w_emit) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end

            if (w_retire) begin
                r_prev  <= w_calc.cmd;
                r_phase <= w_calc.phase;
                r_brake <= w_calc.brake;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_power       <= i_in.power;
            r_brake_write <= i_in.brake_write;
            r_brake_value <= i_in.brake_value;
        end
        if (w_emit) begin
            if (w_need_blank) begin
                r_out_blanking <= 1'b1;
                r_out_leg_a    <= '0;
                r_out_leg_b    <= '0;
                r_out_last     <= 1'b0;
            end else begin
                r_out_blanking <= 1'b0;
                r_out_leg_a    <= w_calc.leg_a;
                r_out_leg_b    <= w_calc.leg_b;
                r_out_last     <= 1'b1;
            end
        end
    end

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Testbench of the H-bridge PWM drive: a scoreboard predicts the blanking and
// drive words of every accepted command word and checks each accepted output
// word against them, through directed commands and random settings and stalls.
// ----------------------------------------------------------------------------
module tb;
    import hpd_pkg::*;

    localparam int CYCLE_LIMIT    = 200000;
    localparam int RX_HOLD_CYCLES = 300;
    localparam int SETTLE_CYCLES  = 4;
    localparam int REPORT_MAX     = 50;

    typedef struct {
        logic             blanking;
        logic [LEG_W-1:0] leg_a;
        logic [LEG_W-1:0] leg_b;
        logic             last;
    } t_drive_word;

    class hpd_drive_scoreboard;
        t_cfg                     cfg;
        logic signed [CMD_W-1:0]  prev_cmd;
        logic [PERIOD_W-1:0]      phase;
        logic                     brake;
        t_drive_word              pending_words[$];
        int                       errors;

        function new();
            cfg.inverse = 1'b0;
            cfg.hw_pwm  = 1'b1;
            cfg.period  = PERIOD_RESET;
            prev_cmd    = '0;
            phase       = '0;
            brake       = 1'b0;
            errors      = 0;
        endfunction

        function int pending();
            return pending_words.size();
        endfunction

        function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            case (idx)
                CFG_INVERSE: cfg.inverse = val[0];
                CFG_HW_PWM:  cfg.hw_pwm  = val[0];
                CFG_PERIOD:  cfg.period  = val[PERIOD_W-1:0];
                default: ;
            endcase
        endfunction

        function void note_command(logic signed [POWER_W-1:0] power, logic bw, logic bv);
            int               cmd;
            int               mag;
            int               nxt;
            logic [LEG_W-1:0] a;
            logic [LEG_W-1:0] b;
            logic [LEG_W-1:0] drive;
            t_drive_word      w;
            if (bw) brake = bv;
            cmd = int'(power);
            if (cfg.inverse) cmd = -cmd;
            if (cmd != int'(prev_cmd)) begin
                prev_cmd = cmd[CMD_W-1:0];
                w = '{blanking: 1'b1, leg_a: '0, leg_b: '0, last: 1'b0};
                pending_words.push_back(w);
            end
            if (cmd > int'(DUTY_MAX)) cmd = int'(DUTY_MAX);
            if (cmd < -int'(DUTY_MAX)) cmd = -int'(DUTY_MAX);
            mag = (cmd < 0) ? -cmd : cmd;
            a = '0;
            b = '0;
            if (cmd != 0) begin
                if (cfg.hw_pwm) drive = mag[LEG_W-1:0];
                else drive = (int'(phase) * int'(DUTY_MAX) < int'(cfg.period) * mag) ?
                             LEVEL_ON : '0;
                if (cmd > 0) a = drive;
                else b = drive;
            end else if (brake) begin
                a = cfg.hw_pwm ? DUTY_MAX : LEVEL_ON;
                b = a;
            end
            w = '{blanking: 1'b0, leg_a: a, leg_b: b, last: 1'b1};
            pending_words.push_back(w);
            nxt = int'(phase) + 1;
            phase = (nxt > int'(cfg.period)) ? '0 : nxt[PERIOD_W-1:0];
        endfunction

        task report(string msg);
            errors++;
            if (errors <= REPORT_MAX) $display("mismatch: %s", msg);
        endtask

        task check_word(logic blanking, logic [LEG_W-1:0] a, logic [LEG_W-1:0] b,
                        logic last);
            t_drive_word w;
            if (pending_words.size() == 0) begin
                report($sformatf("unexpected word blanking=%0b a=%0d b=%0d last=%0b",
                                 blanking, a, b, last));
            end else begin
                w = pending_words.pop_front();
                if (blanking !== w.blanking)
                    report($sformatf("blanking %0b, want %0b", blanking, w.blanking));
                if (a !== w.leg_a)
                    report($sformatf("leg_a %0d, want %0d", a, w.leg_a));
                if (b !== w.leg_b)
                    report($sformatf("leg_b %0d, want %0d", b, w.leg_b));
                if (last !== w.last)
                    report($sformatf("last %0b, want %0b", last, w.last));
            end
        endtask
    endclass

    logic i_clk;
    logic i_rst_n;

    hpd_in_if  cmd_if ();
    hpd_out_if drv_if ();
    hpd_cfg_if reg_if ();

    hbridge_pwm_drive u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (cmd_if),
        .o_out   (drv_if),
        .i_cfg   (reg_if)
    );

    hpd_drive_scoreboard sb;
    int                       cycles;
    bit                       tx_gaps;
    bit                       rx_gaps;
    bit                       rx_hold;
    logic signed [POWER_W-1:0] last_power;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && drv_if.valid && drv_if.ready)
            sb.check_word(drv_if.blanking, drv_if.leg_a, drv_if.leg_b, drv_if.last);
    end

    // output side: random stall bursts, plus one long hold on request
    initial begin
        int n;
        drv_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (rx_hold) begin
                drv_if.ready <= 1'b0;
                repeat (RX_HOLD_CYCLES) @(posedge i_clk);
                rx_hold = 1'b0;
                drv_if.ready <= 1'b1;
            end else if (rx_gaps && $urandom_range(0, 5) == 0) begin
                n = $urandom_range(1, 15);
                drv_if.ready <= 1'b0;
                repeat (n) @(posedge i_clk);
                drv_if.ready <= 1'b1;
            end else begin
                drv_if.ready <= 1'b1;
            end
        end
    end

    task automatic send_word(input logic signed [POWER_W-1:0] p, input logic bw,
                             input logic bv);
        int n;
        cmd_if.valid       <= 1'b1;
        cmd_if.power       <= p;
        cmd_if.brake_write <= bw;
        cmd_if.brake_value <= bv;
        @(posedge i_clk);
        while (!cmd_if.ready) @(posedge i_clk);
        sb.note_command(p, bw, bv);
        last_power = p;
        if (tx_gaps && $urandom_range(0, 5) == 0) begin
            n = $urandom_range(1, 15);
            cmd_if.valid <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    task automatic wait_drained();
        cmd_if.valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        reg_if.valid <= 1'b1;
        reg_if.index <= idx;
        reg_if.data  <= val;
        @(posedge i_clk);
        while (!reg_if.ready) @(posedge i_clk);
        sb.set_register(idx, val);
    endtask

    task automatic apply_setting(input logic inv, input logic hw,
                                 input logic [PERIOD_W-1:0] period);
        wait_drained();
        write_reg(CFG_INVERSE, CFG_DATA_W'(inv));
        write_reg(CFG_HW_PWM, CFG_DATA_W'(hw));
        write_reg(CFG_PERIOD, CFG_DATA_W'(period));
        reg_if.valid <= 1'b0;
    endtask

    function automatic logic signed [POWER_W-1:0] next_power();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 30) return last_power;
        if (sel < 42) return '0;
        if (sel < 55) begin
            case ($urandom_range(0, 4))
                0: return POWER_W'(-256);
                1: return POWER_W'(-255);
                2: return POWER_W'(255);
                3: return POWER_W'(1);
                default: return POWER_W'(-1);
            endcase
        end
        return POWER_W'($urandom_range(0, (1 << POWER_W) - 1));
    endfunction

    task automatic run_random(input int count);
        repeat (count)
            send_word(next_power(), $urandom_range(0, 3) == 0, 1'($urandom_range(0, 1)));
    endtask

    initial begin
        sb      = new();
        cycles  = 0;
        tx_gaps = 1'b0;
        rx_gaps = 1'b0;
        rx_hold = 1'b0;
        last_power = '0;
        i_rst_n <= 1'b0;
        cmd_if.valid       <= 1'b0;
        cmd_if.power       <= '0;
        cmd_if.brake_write <= 1'b0;
        cmd_if.brake_value <= 1'b0;
        reg_if.valid <= 1'b0;
        reg_if.index <= '0;
        reg_if.data  <= '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset settings: duty mode, brake on and off, clamping, repeats
        send_word(POWER_W'(0), 1'b0, 1'b0);
        send_word(POWER_W'(0), 1'b1, 1'b1);
        send_word(POWER_W'(255), 1'b0, 1'b0);
        send_word(POWER_W'(255), 1'b0, 1'b0);
        send_word(POWER_W'(-256), 1'b0, 1'b0);
        send_word(POWER_W'(-255), 1'b0, 1'b0);
        send_word(POWER_W'(1), 1'b0, 1'b0);
        send_word(POWER_W'(-1), 1'b0, 1'b0);
        send_word(POWER_W'(0), 1'b0, 1'b0);
        send_word(POWER_W'(0), 1'b1, 1'b0);
        send_word(POWER_W'(128), 1'b1, 1'b1);
        send_word(POWER_W'(0), 1'b0, 1'b0);

        // inverted software mode: -256 stored as 256, so a repeat gives no blanking
        apply_setting(1'b1, 1'b0, 8'd20);
        send_word(POWER_W'(-256), 1'b0, 1'b0);
        send_word(POWER_W'(-256), 1'b0, 1'b0);
        send_word(POWER_W'(255), 1'b0, 1'b0);
        send_word(POWER_W'(0), 1'b1, 1'b1);
        send_word(POWER_W'(0), 1'b1, 1'b0);
        send_word(POWER_W'(1), 1'b0, 1'b0);
        send_word(POWER_W'(-1), 1'b0, 1'b0);
        send_word(POWER_W'(100), 1'b0, 1'b0);
        send_word(POWER_W'(-100), 1'b0, 1'b0);

        apply_setting(1'b0, 1'b1, PERIOD_RESET);
        tx_gaps = 1'b1;
        rx_gaps = 1'b1;
        run_random(60);

        apply_setting(1'b0, 1'b0, 8'd20);
        run_random(60);

        // hold the output long enough for the input to back up
        apply_setting(1'b1, 1'b0, 8'd1);
        rx_hold = 1'b1;
        run_random(60);

        apply_setting(1'b0, 1'b0, 8'd255);
        tx_gaps = 1'b0;
        run_random(300 / 10);
        wait_drained();
        run_random(300 / 10);

        apply_setting(1'b1, 1'b1, 8'd255);
        tx_gaps = 1'b1;
        rx_gaps = 1'b0;
        run_random(60);

        apply_setting(1'b0, 1'b0, 8'd0);
        rx_gaps = 1'b1;
        run_random(60);

        apply_setting(1'b1, 1'b0, 8'd3);
        run_random(60);

        apply_setting(1'b0, 1'b1, 8'd128);
        run_random(50);

        repeat (3) begin
            apply_setting(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                          PERIOD_W'($urandom_range(0, 255)));
            tx_gaps = $urandom_range(0, 3) != 0;
            rx_gaps = $urandom_range(0, 3) != 0;
            run_random(40);
        end

        // no idling on either side to the end
        apply_setting(1'b0, 1'b0, 8'd10);
        tx_gaps = 1'b0;
        rx_gaps = 1'b0;
        run_random(60);

        wait_drained();
        repeat (10) @(posedge i_clk);
        if (sb.errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
